// ----- rtl/cir_pkg.sv -----
// Shared types, register indexes and saturation helper for the collision impulse resolver.
`default_nettype none

package cir_pkg;

   // Configuration register indexes.
   localparam logic CSR_PENETRATION_SLOP     = 1'b0;
   localparam logic CSR_SEPARATION_THRESHOLD = 1'b1;

   localparam logic [7:0] SLOP_RESET      = 8'd5;
   localparam logic [7:0] THRESHOLD_RESET = 8'd3;

   // Quotient bits resolved by the divider, one per stage.
   localparam int DIV_BITS = 17;
   // Front stages, divider stages (one setup stage plus one per bit), output stage.
   localparam int FRONT_STAGES = 6;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_BITS + 2;

   typedef struct packed {
      logic [47:0]      vel_one;
      logic [47:0]      vel_two;
      logic [47:0]      normal;
      logic [47:0]      pos;
      logic [8:0]       e;
      logic [15:0]      w1;
      logic [15:0]      w2;
      logic [16:0]      den;
      logic             both_zero;
      logic             skip;
      logic [2:0][16:0] rv;
      logic [2:0][31:0] pprod;
      logic [2:0][32:0] prod;
      logic [34:0]      dot;
      logic [44:0]      mprod;
      logic [30:0]      s;
      logic [2:0][44:0] qmag;
      logic [2:0]       qneg;
   } pipe_type;

   // Lanes 0..2 are body one x/y/z, lanes 3..5 body two x/y/z.
   typedef struct packed {
      logic [47:0]      vel_one;
      logic [47:0]      vel_two;
      logic [47:0]      pos;
      logic             applied;
      logic [16:0]      den;
      logic [5:0]       neg;
      logic [5:0]       ovf;
      logic [5:0][33:0] rem;
      logic [5:0][16:0] quo;
   } div_type;

   function automatic logic [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'h7fff;
      end else if (v < -19'sd32768) begin
         return 16'h8000;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/collision_impulse_resolver_top.sv -----
// Pipelined impulse-based collision response for one contact per beat.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    velocities, normal, masses, bounces, depth, position
//   rsp_      out        rsp_valid/stall    new velocities, new position, impulse_applied
//   csr_      in         csr_write          csr_index, csr_data (8 bits)
//
// A beat passes 25 register stages, and one beat can enter every cycle while no finished result
// is stalled. Most of the stages belong to the 17-stage restoring divider that scales the
// impulse by the mass ratio, one quotient bit per stage. Reset clears the valid bits and
// loads the register defaults. A stall on the result side while a finished result waits
// freezes the whole pipeline and is seen by the request side in the same cycle.
`default_nettype none

module collision_impulse_resolver_top
   import cir_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [47:0] req_velocity_one,
   input  wire logic [47:0] req_velocity_two,
   input  wire logic [47:0] req_contact_normal,
   input  wire logic [15:0] req_mass_one,
   input  wire logic [15:0] req_mass_two,
   input  wire logic [8:0]  req_bounce_one,
   input  wire logic [8:0]  req_bounce_two,
   input  wire logic [15:0] req_penetration_depth,
   input  wire logic [47:0] req_position_one,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [47:0]      rsp_new_velocity_one,
   output logic [47:0]      rsp_new_velocity_two,
   output logic [47:0]      rsp_new_position_one,
   output logic             rsp_impulse_applied,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   logic [7:0] slop_ff, thr_ff;
   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic advance;

   pipe_type p_ff [1:FRONT_STAGES];
   pipe_type p_in [1:FRONT_STAGES];
   div_type  dv_ff [0:DIV_BITS];
   div_type  dv_in [0:DIV_BITS];

   logic [47:0] nv1_in, nv2_in;
   logic [47:0] nv1_ff, nv2_ff, npos_ff;
   logic        applied_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff <= SLOP_RESET;
         thr_ff  <= THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PENETRATION_SLOP:     slop_ff <= csr_data;
            CSR_SEPARATION_THRESHOLD: thr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one; it holds only while a finished result is stalled.
   assign advance   = !(vld_ff[PIPE_STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in    = {vld_ff[PIPE_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: relative velocity, restitution, weights, depth products.
   always_comb begin
      p_in[1] = '0;
      p_in[1].vel_one   = req_velocity_one;
      p_in[1].vel_two   = req_velocity_two;
      p_in[1].normal    = req_contact_normal;
      p_in[1].pos       = req_position_one;
      p_in[1].e         = (req_bounce_one < req_bounce_two) ? req_bounce_one : req_bounce_two;
      p_in[1].both_zero = (req_mass_one == 16'd0) && (req_mass_two == 16'd0);
      if (req_mass_one == 16'd0) begin
         p_in[1].w1  = 16'd0;
         p_in[1].w2  = 16'd1;
         p_in[1].den = 17'd1;
      end else if (req_mass_two == 16'd0) begin
         p_in[1].w1  = 16'd1;
         p_in[1].w2  = 16'd0;
         p_in[1].den = 17'd1;
      end else begin
         p_in[1].w1  = req_mass_two;
         p_in[1].w2  = req_mass_one;
         p_in[1].den = {1'b0, req_mass_one} + {1'b0, req_mass_two};
      end
      for (int k = 0; k < 3; k++) begin
         p_in[1].rv[k] = {req_velocity_one[16*k+15], req_velocity_one[16*k +: 16]}
                       - {req_velocity_two[16*k+15], req_velocity_two[16*k +: 16]};
         p_in[1].pprod[k] = 32'($signed({{16{req_contact_normal[16*k+15]}},
                                         req_contact_normal[16*k +: 16]})
                              * $signed({16'd0, req_penetration_depth}));
      end
   end

   // Stage 2: dot product terms and the finished position push.
   always_comb begin
      logic [31:0] pmag, pround;
      logic [17:0] rq;
      logic [18:0] pos_sum, push;
      p_in[2] = p_ff[1];
      for (int k = 0; k < 3; k++) begin
         p_in[2].prod[k] = 33'($signed({{16{p_ff[1].rv[k][16]}}, p_ff[1].rv[k]})
                             * $signed({{17{p_ff[1].normal[16*k+15]}},
                                        p_ff[1].normal[16*k +: 16]}));
         pmag    = p_ff[1].pprod[k][31] ? -p_ff[1].pprod[k] : p_ff[1].pprod[k];
         pround  = pmag + 32'd8192;
         rq      = pround[31:14];
         push    = p_ff[1].pprod[k][31] ? -{1'b0, rq} : {1'b0, rq};
         pos_sum = {{3{p_ff[1].pos[16*k+15]}}, p_ff[1].pos[16*k +: 16]} + push
                 + {11'd0, slop_ff};
         if (p_ff[1].normal[16*k +: 16] != 16'd0) begin
            p_in[2].pos[16*k +: 16] = sat16(pos_sum);
         end
      end
   end

   // Stage 3: dot product and the skip decision.
   always_comb begin
      p_in[3] = p_ff[2];
      p_in[3].dot = {{2{p_ff[2].prod[0][32]}}, p_ff[2].prod[0]}
                  + {{2{p_ff[2].prod[1][32]}}, p_ff[2].prod[1]}
                  + {{2{p_ff[2].prod[2][32]}}, p_ff[2].prod[2]};
      p_in[3].skip = p_ff[2].both_zero
                   || ($signed(p_in[3].dot) > $signed({13'd0, thr_ff, 14'd0}));
   end

   // Stage 4: closing speed times (1 + e).
   always_comb begin
      logic [34:0] closing;
      logic [9:0]  ek;
      p_in[4] = p_ff[3];
      closing = -p_ff[3].dot;
      ek      = 10'd256 + {1'b0, p_ff[3].e};
      p_in[4].mprod = 45'($signed({35'd0, ek}) * $signed({{10{closing[34]}}, closing}));
   end

   // Stage 5: scale back to Q.16 with rounding.
   always_comb begin
      logic [44:0] mmag, mround;
      logic [30:0] qq;
      p_in[5] = p_ff[4];
      mmag   = p_ff[4].mprod[44] ? -p_ff[4].mprod : p_ff[4].mprod;
      mround = mmag + 45'd8192;
      qq     = mround[44:14];
      p_in[5].s = p_ff[4].mprod[44] ? -qq : qq;
   end

   // Stage 6: impulse along each normal axis, as sign and magnitude.
   always_comb begin
      logic [46:0] q, qm;
      p_in[6] = p_ff[5];
      for (int k = 0; k < 3; k++) begin
         q  = 47'($signed({{16{p_ff[5].s[30]}}, p_ff[5].s})
                * $signed({{31{p_ff[5].normal[16*k+15]}}, p_ff[5].normal[16*k +: 16]}));
         qm = q[46] ? -q : q;
         p_in[6].qmag[k] = qm[44:0];
         p_in[6].qneg[k] = q[46];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 1; i <= FRONT_STAGES; i++) begin
            p_ff[i] <= p_in[i];
         end
      end
   end

   // Divider setup: weight the impulse, fold in the rounding half, drop 22 fraction bits.
   // A quotient that cannot fit in 17 bits saturates the velocity either way.
   always_comb begin
      logic [61:0] a;
      logic [39:0] t;
      logic [15:0] w;
      dv_in[0] = '0;
      dv_in[0].vel_one = p_ff[FRONT_STAGES].vel_one;
      dv_in[0].vel_two = p_ff[FRONT_STAGES].vel_two;
      dv_in[0].pos     = p_ff[FRONT_STAGES].pos;
      dv_in[0].applied = !p_ff[FRONT_STAGES].skip;
      dv_in[0].den     = p_ff[FRONT_STAGES].den;
      for (int j = 0; j < 6; j++) begin
         w = (j < 3) ? p_ff[FRONT_STAGES].w1 : p_ff[FRONT_STAGES].w2;
         a = {17'd0, p_ff[FRONT_STAGES].qmag[j % 3]} * {46'd0, w}
           + {24'd0, p_ff[FRONT_STAGES].den, 21'd0};
         t = a[61:22];
         dv_in[0].neg[j] = p_ff[FRONT_STAGES].qneg[j % 3];
         dv_in[0].ovf[j] = t >= {6'd0, p_ff[FRONT_STAGES].den, 17'd0};
         dv_in[0].rem[j] = t[33:0];
      end
   end

   // Restoring division, most significant quotient bit first.
   always_comb begin
      logic [33:0] dsh;
      for (int k = 1; k <= DIV_BITS; k++) begin
         dv_in[k] = dv_ff[k-1];
         dsh = {17'd0, dv_ff[k-1].den} << (DIV_BITS - k);
         for (int j = 0; j < 6; j++) begin
            if (dv_ff[k-1].rem[j] >= dsh) begin
               dv_in[k].rem[j] = dv_ff[k-1].rem[j] - dsh;
               dv_in[k].quo[j][DIV_BITS-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= DIV_BITS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   // Output stage: apply the velocity change with saturation, or pass the velocities through when skipped.
   always_comb begin
      logic        add;
      logic [15:0] v, r;
      logic [18:0] dext, vsum;
      for (int j = 0; j < 6; j++) begin
         v    = (j < 3) ? dv_ff[DIV_BITS].vel_one[16*(j%3) +: 16]
                        : dv_ff[DIV_BITS].vel_two[16*(j%3) +: 16];
         // Body one gains the impulse, body two loses it.
         add  = (j < 3) ? !dv_ff[DIV_BITS].neg[j] : dv_ff[DIV_BITS].neg[j];
         dext = {2'd0, dv_ff[DIV_BITS].quo[j]};
         vsum = {{3{v[15]}}, v} + (add ? dext : -dext);
         if (dv_ff[DIV_BITS].ovf[j]) begin
            r = add ? 16'h7fff : 16'h8000;
         end else begin
            r = sat16(vsum);
         end
         if (!dv_ff[DIV_BITS].applied) begin
            r = v;
         end
         if (j < 3) begin
            nv1_in[16*(j%3) +: 16] = r;
         end else begin
            nv2_in[16*(j%3) +: 16] = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nv1_ff     <= nv1_in;
         nv2_ff     <= nv2_in;
         npos_ff    <= dv_ff[DIV_BITS].pos;
         applied_ff <= dv_ff[DIV_BITS].applied;
      end
   end

   assign rsp_valid            = vld_ff[PIPE_STAGES-1];
   assign rsp_new_velocity_one = nv1_ff;
   assign rsp_new_velocity_two = nv2_ff;
   assign rsp_new_position_one = npos_ff;
   assign rsp_impulse_applied  = applied_ff;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the collision impulse resolver, with its own predictor.
`default_nettype none

module tb
   import cir_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [47:0] vel_one;
      logic [47:0] vel_two;
      logic [47:0] normal;
      logic [15:0] mass_one;
      logic [15:0] mass_two;
      logic [8:0]  bounce_one;
      logic [8:0]  bounce_two;
      logic [15:0] depth;
      logic [47:0] pos;
   } contact_type;

   typedef struct {
      logic [47:0] vel_one;
      logic [47:0] vel_two;
      logic [47:0] pos;
      logic        applied;
   } response_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [47:0] req_velocity_one;
   logic [47:0] req_velocity_two;
   logic [47:0] req_contact_normal;
   logic [15:0] req_mass_one;
   logic [15:0] req_mass_two;
   logic [8:0]  req_bounce_one;
   logic [8:0]  req_bounce_two;
   logic [15:0] req_penetration_depth;
   logic [47:0] req_position_one;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [47:0] rsp_new_velocity_one;
   logic [47:0] rsp_new_velocity_two;
   logic [47:0] rsp_new_position_one;
   logic        rsp_impulse_applied;
   logic        csr_write;
   logic        csr_index;
   logic [7:0]  csr_data;

   contact_type  contact_q[$];
   response_type response_q[$];
   logic [7:0] slop_copy;
   logic [7:0] threshold_copy;
   int idle_pct;
   int error_count;
   int contacts_sent;
   int impulses_seen;
   int watchdog;

   collision_impulse_resolver_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_velocity_one(req_velocity_one), .req_velocity_two(req_velocity_two),
      .req_contact_normal(req_contact_normal), .req_mass_one(req_mass_one),
      .req_mass_two(req_mass_two), .req_bounce_one(req_bounce_one),
      .req_bounce_two(req_bounce_two), .req_penetration_depth(req_penetration_depth),
      .req_position_one(req_position_one),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_velocity_one(rsp_new_velocity_one),
      .rsp_new_velocity_two(rsp_new_velocity_two),
      .rsp_new_position_one(rsp_new_position_one),
      .rsp_impulse_applied(rsp_impulse_applied),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint lane(logic [47:0] packed_vec, int k);
      return longint'($signed(packed_vec[16*k +: 16]));
   endfunction

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'h7fff;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // Division rounded to nearest, ties away from zero.
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic response_type resolve_contact(contact_type c);
      response_type r;
      longint dot;
      longint e;
      longint s;
      longint q;
      longint w1;
      longint w2;
      longint den;
      longint p;
      dot = 0;
      for (int k = 0; k < 3; k++) begin
         dot += (lane(c.vel_one, k) - lane(c.vel_two, k)) * lane(c.normal, k);
      end
      r.vel_one = c.vel_one;
      r.vel_two = c.vel_two;
      r.applied = 1'b0;
      if (!(c.mass_one == 0 && c.mass_two == 0) &&
          !(-dot < -(longint'(threshold_copy) <<< 14))) begin
         e = (c.bounce_one < c.bounce_two) ? c.bounce_one : c.bounce_two;
         s = round_div((256 + e) * -dot, 64'sd1 <<< 14);
         if (c.mass_one == 0) begin
            w1 = 0; w2 = 1; den = 1;
         end else if (c.mass_two == 0) begin
            w1 = 1; w2 = 0; den = 1;
         end else begin
            w1 = c.mass_two; w2 = c.mass_one; den = longint'(c.mass_one) + c.mass_two;
         end
         for (int k = 0; k < 3; k++) begin
            q = s * lane(c.normal, k);
            r.vel_one[16*k +: 16] = clamp16(lane(c.vel_one, k) + round_div(q * w1, den <<< 22));
            r.vel_two[16*k +: 16] = clamp16(lane(c.vel_two, k) - round_div(q * w2, den <<< 22));
         end
         r.applied = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
         p = lane(c.pos, k);
         if (lane(c.normal, k) != 0) begin
            p = p + round_div(lane(c.normal, k) * c.depth, 64'sd1 <<< 14) + slop_copy;
         end
         r.pos[16*k +: 16] = clamp16(p);
      end
      return r;
   endfunction

   function automatic logic [15:0] pick_component(bit is_normal);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 16'h0;
      end else if (sel == 1) begin
         return 16'($urandom());
      end else if (sel == 2) begin
         return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      end
      if (is_normal) begin
         return 16'($signed($urandom_range(0, 32768)) - 16384);
      end
      return 16'($signed($urandom_range(0, 8192)) - 4096);
   endfunction

   function automatic logic [15:0] pick_mass();
      case ($urandom_range(0, 7))
         0: return 16'h0;
         1: return 16'hffff;
         2: return 16'($urandom());
         default: return 16'($urandom_range(1, 2048));
      endcase
   endfunction

   function automatic contact_type random_contact();
      contact_type c;
      for (int k = 0; k < 3; k++) begin
         c.vel_one[16*k +: 16] = pick_component(1'b0);
         c.vel_two[16*k +: 16] = pick_component(1'b0);
         c.normal[16*k +: 16]  = pick_component(1'b1);
         c.pos[16*k +: 16]     = pick_component(1'b0);
      end
      c.mass_one   = pick_mass();
      c.mass_two   = pick_mass();
      c.bounce_one = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 256));
      c.bounce_two = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 256));
      c.depth      = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
      return c;
   endfunction

   function automatic contact_type fixed_contact(logic [47:0] v1, logic [47:0] v2,
                                                 logic [47:0] n, logic [15:0] m1,
                                                 logic [15:0] m2, logic [8:0] b1,
                                                 logic [8:0] b2, logic [15:0] d,
                                                 logic [47:0] p);
      contact_type c;
      c.vel_one = v1; c.vel_two = v2; c.normal = n; c.mass_one = m1; c.mass_two = m2;
      c.bounce_one = b1; c.bounce_two = b2; c.depth = d; c.pos = p;
      return c;
   endfunction

   // Driver: one beat per acceptance, refilled from the pending contacts.
   always @(posedge clock) begin
      contact_type next_c;
      logic        hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         hold = req_valid;
         if (req_valid && !req_stall) begin
            response_q.push_back(resolve_contact('{req_velocity_one, req_velocity_two,
               req_contact_normal, req_mass_one, req_mass_two, req_bounce_one,
               req_bounce_two, req_penetration_depth, req_position_one}));
            contacts_sent++;
            hold = 1'b0;
         end
         if (!hold) begin
            if (contact_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_c = contact_q.pop_front();
               req_velocity_one      <= next_c.vel_one;
               req_velocity_two      <= next_c.vel_two;
               req_contact_normal    <= next_c.normal;
               req_mass_one          <= next_c.mass_one;
               req_mass_two          <= next_c.mass_two;
               req_bounce_one        <= next_c.bounce_one;
               req_bounce_two        <= next_c.bounce_two;
               req_penetration_depth <= next_c.depth;
               req_position_one      <= next_c.pos;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (response_q.size() == 0) begin
               $display("%0t: unexpected result beat, actual v1=%h v2=%h p=%h imp=%b", $time,
                        rsp_new_velocity_one, rsp_new_velocity_two, rsp_new_position_one,
                        rsp_impulse_applied);
               error_count++;
            end else begin
               want = response_q.pop_front();
               if (rsp_new_velocity_one !== want.vel_one) begin
                  $display("%0t: new_velocity_one expected %h actual %h", $time,
                           want.vel_one, rsp_new_velocity_one);
                  error_count++;
               end
               if (rsp_new_velocity_two !== want.vel_two) begin
                  $display("%0t: new_velocity_two expected %h actual %h", $time,
                           want.vel_two, rsp_new_velocity_two);
                  error_count++;
               end
               if (rsp_new_position_one !== want.pos) begin
                  $display("%0t: new_position_one expected %h actual %h", $time,
                           want.pos, rsp_new_position_one);
                  error_count++;
               end
               if (rsp_impulse_applied !== want.applied) begin
                  $display("%0t: impulse_applied expected %b actual %b", $time,
                           want.applied, rsp_impulse_applied);
                  error_count++;
               end
               if (want.applied) begin
                  impulses_seen++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   // The watchdog only runs while work is outstanding.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (contact_q.size() == 0 && !req_valid && response_q.size() == 0)) begin
         watchdog <= 0;
      end else begin
         watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic write_csr(logic index, logic [7:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      if (index == CSR_PENETRATION_SLOP) begin
         slop_copy = value;
      end else begin
         threshold_copy = value;
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Checked on the falling edge so that the driver's updates at the rising edge have settled.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (contact_q.size() != 0 || req_valid || response_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         contact_q.push_back(random_contact());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_velocity_one = '0; req_velocity_two = '0; req_contact_normal = '0;
      req_mass_one = '0; req_mass_two = '0; req_bounce_one = '0; req_bounce_two = '0;
      req_penetration_depth = '0; req_position_one = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0; csr_index = CSR_PENETRATION_SLOP; csr_data = '0;
      slop_copy = SLOP_RESET;
      threshold_copy = THRESHOLD_RESET;
      idle_pct = 20;
      error_count = 0; contacts_sent = 0; impulses_seen = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed contacts at the register defaults.
      contact_q.push_back(fixed_contact(48'h0000_0000_0100, 48'h0000_0000_ff00,
         48'h0000_0000_4000, 16'h0100, 16'h0100, 9'd256, 9'd128, 16'h0080, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0000_0100, 48'h0000_0000_ff00,
         48'h0000_0000_4000, 16'h0, 16'h0, 9'd256, 9'd256, 16'h0080, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0000_0100, 48'h0000_0000_ff00,
         48'h0000_0000_4000, 16'h0, 16'h0200, 9'd100, 9'd200, 16'h0100, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0000_0100, 48'h0000_0000_ff00,
         48'h0000_0000_4000, 16'h0300, 16'h0, 9'd511, 9'd511, 16'h0100, 48'h0));
      // Negative dot products, below the separation threshold, so each one gets an impulse.
      contact_q.push_back(fixed_contact(48'h0000_0000_ff00, 48'h0000_0000_0100,
         48'h0000_0000_4000, 16'h0100, 16'h0100, 9'd0, 9'd0, 16'h0, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0000_0000, 48'h0000_0000_0003,
         48'h0000_0000_4000, 16'h0100, 16'h0100, 9'd0, 9'd0, 16'h0, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0000_0000, 48'h0000_0000_0004,
         48'h0000_0000_4000, 16'h0100, 16'h0100, 9'd0, 9'd0, 16'h0, 48'h0));
      // Zero normal, non-unit normals, saturation of every output.
      contact_q.push_back(fixed_contact(48'h1234_5678_9abc, 48'h0, 48'h0, 16'h0100,
         16'h0100, 9'd256, 9'd256, 16'hffff, 48'h7fff_8000_0001));
      contact_q.push_back(fixed_contact(48'h7fff_7fff_7fff, 48'h8000_8000_8000,
         48'h7fff_7fff_7fff, 16'hffff, 16'hffff, 9'd511, 9'd511, 16'hffff,
         48'h7fff_7fff_7fff));
      contact_q.push_back(fixed_contact(48'h8000_8000_8000, 48'h7fff_7fff_7fff,
         48'h8000_8000_8000, 16'hffff, 16'h0001, 9'd511, 9'd256, 16'hffff,
         48'h8000_8000_8000));
      contact_q.push_back(fixed_contact(48'h7fff_7fff_7fff, 48'h8000_8000_8000,
         48'h8000_8000_8000, 16'h0001, 16'hffff, 9'd0, 9'd511, 16'hffff,
         48'h8000_8000_8000));
      contact_q.push_back(fixed_contact(48'h0100_0100_0100, 48'hff00_ff00_ff00,
         48'h2000_2000_2000, 16'h0001, 16'h0001, 9'd1, 9'd2, 16'h0001, 48'h0));
      contact_q.push_back(fixed_contact(48'h0000_0200_0000, 48'h0, 48'h0000_c000_0000,
         16'hffff, 16'hffff, 9'h1ff, 9'h1ff, 16'h8000, 48'hffff_ffff_ffff));
      idle_pct = 0;
      drain();

      // Long stretch with no idling at all, then idling on both sides.
      queue_random(140);
      drain();
      idle_pct = 20;
      queue_random(130);
      drain();

      write_csr(CSR_PENETRATION_SLOP, 8'd0);
      write_csr(CSR_SEPARATION_THRESHOLD, 8'd0);
      queue_random(120);
      drain();

      write_csr(CSR_PENETRATION_SLOP, 8'd255);
      write_csr(CSR_SEPARATION_THRESHOLD, 8'd255);
      queue_random(120);
      drain();

      write_csr(CSR_PENETRATION_SLOP, 8'($urandom()));
      write_csr(CSR_SEPARATION_THRESHOLD, 8'($urandom()));
      queue_random(130);
      drain();

      $display("Resolved %0d contacts over four register settings; %0d applied an impulse.",
               contacts_sent, impulses_seen);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/cir_pkg.sv
rtl/collision_impulse_resolver_top.sv
dv/tb.sv
